>>> hdl/ipv4_header_checker_unit_assert.svh
// ---------------------------------------------------------------------------
// IPv4 header checker assertion macros
// Shared concurrent assertion forms, clocked on clk, masked during rst_n low.
// ---------------------------------------------------------------------------
`ifndef IPV4_HEADER_CHECKER_UNIT_ASSERT_SVH
`define IPV4_HEADER_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define IHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ihc_pkg.sv
// ---------------------------------------------------------------------------
// IPv4 header checker package
// Item types, verdict codes and header byte offsets.
// ---------------------------------------------------------------------------
package ihc_pkg;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_VERSION  = 3'd1,
    VERDICT_LENGTH   = 3'd2,
    VERDICT_TTL      = 3'd3,
    VERDICT_CHECKSUM = 3'd4,
    VERDICT_DEST     = 3'd5
  } ihc_verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } ihc_in_t;

  typedef struct packed {
    ihc_verdict_t verdict;
    logic [5:0]   header_bytes;
  } ihc_out_t;

  // item held in the input stage
  typedef struct packed {
    logic    valid;
    ihc_in_t item;
  } ihc_stage_t;

  localparam logic [3:0] IP_VERSION    = 4'd4;
  localparam logic [3:0] IHL_MIN       = 4'd5;
  localparam logic [5:0] POS_TTL       = 6'd8;
  localparam logic [5:0] POS_CSUM_HI   = 6'd10;
  localparam logic [5:0] POS_CSUM_LO   = 6'd11;
  localparam logic [5:0] POS_DST_FIRST = 6'd16;
  localparam logic [5:0] POS_DST_LAST  = 6'd19;
  localparam logic [5:0] POS_MAX       = 6'd59;

endpackage

>>> hdl/ipv4_header_checker_unit.sv
// ---------------------------------------------------------------------------
// IPv4 header checker
// Parses IPv4 headers from a byte stream and gives at most one verdict per packet.
// ---------------------------------------------------------------------------
//  channel  ports                        item
//  in       in_valid/in_ready/in_data    one packet byte, start flag
//  out      out_valid/out_ready/out_data verdict, header length in bytes
//  cfg      cfg_wr_en/cfg_wr_data        local address, written at once
//
// One byte per cycle sustained while out_ready is high; a verdict leaves from the result register.
// The path is input register, parser logic, result register.
// Synchronous active-low reset; the block then ignores bytes until a start.
// A stalled result holds both registers; the input stays open while either
// register is empty.
// ---------------------------------------------------------------------------
module ipv4_header_checker_unit
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ihc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ihc_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  ihc_stage_t stage;
  logic       advance;
  logic       res_valid;
  ihc_out_t   res;

  ihc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  ihc_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stage       (stage),
    .advance     (advance),
    .res_valid   (res_valid),
    .res         (res)
  );

  ihc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hdl/ihc_in_stage.sv
// ---------------------------------------------------------------------------
// IPv4 header checker input stage
// Registers one accepted byte item ahead of the parser.
// ---------------------------------------------------------------------------
module ihc_in_stage
  import ihc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ihc_in_t    in_data,
  input  logic       advance,
  output ihc_stage_t stage
);

  logic    valid_r;
  ihc_in_t item_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

>>> hdl/ihc_parse.sv
// ---------------------------------------------------------------------------
// IPv4 header checker parser
// Per-byte header state update and the verdict at the deciding byte.
// ---------------------------------------------------------------------------
`include "ipv4_header_checker_unit_assert.svh"

module ihc_parse
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  ihc_stage_t  stage,
  input  logic        advance,
  output logic        res_valid,
  output ihc_out_t    res
);

  logic [31:0] local_addr_r;
  logic [5:0]  pos_r, pos_nxt;
  logic [3:0]  hwords_r, hwords_nxt;
  logic [20:0] sum_r, sum_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] csum_r, csum_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic        ttlz_r, ttlz_nxt;
  logic        vg_r, vg_nxt;

  logic        step;
  logic        start;
  logic [7:0]  b;
  logic [5:0]  pos_c;
  logic [3:0]  hw_eff;
  logic [5:0]  hdr_bytes;
  logic [5:0]  last_pos;
  logic [20:0] sum_add;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [31:0] ones_mask;
  logic        dst_ok;
  logic        ver_err;
  logic        len_err;
  logic        last_byte;

  assign step  = stage.valid && advance;
  assign start = stage.item.packet_start;
  assign b     = stage.item.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
    end else if (cfg_wr_en) begin
      local_addr_r <= cfg_wr_data;
    end
  end

  // start clears the packet state before the byte is looked at
  always_comb begin
    pos_c      = start ? '0 : pos_r;
    hwords_nxt = start ? '0 : hwords_r;
    sum_nxt    = start ? '0 : sum_r;
    pend_nxt   = start ? '0 : pend_r;
    csum_nxt   = start ? '0 : csum_r;
    dst_nxt    = start ? '0 : dst_r;
    ttlz_nxt   = start ? 1'b0 : ttlz_r;
    vg_nxt     = start ? 1'b0 : vg_r;
    pos_nxt    = pos_c;
    ver_err    = 1'b0;
    len_err    = 1'b0;
    last_byte  = 1'b0;

    hw_eff    = (pos_c == '0) ? b[3:0] : hwords_nxt;
    hdr_bytes = {hw_eff, 2'b00};
    last_pos  = hdr_bytes - 6'd1;

    if (!vg_nxt) begin
      if (pos_c == '0 && b[7:4] != IP_VERSION) begin
        vg_nxt  = 1'b1;
        ver_err = 1'b1;
      end else if (pos_c == '0 && b[3:0] < IHL_MIN) begin
        vg_nxt  = 1'b1;
        len_err = 1'b1;
      end else begin
        hwords_nxt = hw_eff;
        if (!pos_c[0]) begin
          pend_nxt = b;
        end else if (pos_c != POS_CSUM_LO) begin
          sum_nxt = sum_nxt + {5'd0, pend_nxt, b};
        end
        if (pos_c == POS_TTL) begin
          ttlz_nxt = (b == 8'd0);
        end
        if (pos_c == POS_CSUM_HI || pos_c == POS_CSUM_LO) begin
          csum_nxt = {csum_nxt[7:0], b};
        end
        if (pos_c >= POS_DST_FIRST && pos_c <= POS_DST_LAST) begin
          dst_nxt = {dst_nxt[23:0], b};
        end
        if (pos_c == last_pos) begin
          vg_nxt    = 1'b1;
          last_byte = 1'b1;
        end else begin
          pos_nxt = pos_c + 6'd1;
        end
      end
    end
  end

  // end-around carry folded twice
  assign sum_add = sum_nxt;
  assign fold1   = {12'd0, sum_add[20:16]} + {1'b0, sum_add[15:0]};
  assign fold2   = {15'd0, fold1[16]} + fold1[15:0];

  // ignore the destination's run of trailing ones (subnet broadcast)
  assign ones_mask = dst_nxt & ~(dst_nxt + 32'd1);
  assign dst_ok    = ((dst_nxt ^ local_addr_r) & ~ones_mask) == 32'd0;

  // early rejects first, then ttl, checksum and destination in turn
  always_comb begin
    res_valid        = step && (ver_err || len_err || last_byte);
    res.header_bytes = last_byte ? hdr_bytes : 6'd0;
    priority if (ver_err) begin
      res.verdict = VERDICT_VERSION;
    end else if (len_err) begin
      res.verdict = VERDICT_LENGTH;
    end else if (ttlz_nxt) begin
      res.verdict = VERDICT_TTL;
    end else if (~fold2 != csum_nxt) begin
      res.verdict = VERDICT_CHECKSUM;
    end else if (!dst_ok) begin
      res.verdict = VERDICT_DEST;
    end else begin
      res.verdict = VERDICT_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hwords_r <= '0;
      sum_r    <= '0;
      pend_r   <= '0;
      csum_r   <= '0;
      dst_r    <= '0;
      ttlz_r   <= 1'b0;
      vg_r     <= 1'b1;
    end else if (step) begin
      pos_r    <= pos_nxt;
      hwords_r <= hwords_nxt;
      sum_r    <= sum_nxt;
      pend_r   <= pend_nxt;
      csum_r   <= csum_nxt;
      dst_r    <= dst_nxt;
      ttlz_r   <= ttlz_nxt;
      vg_r     <= vg_nxt;
    end
  end

  `IHC_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= POS_MAX, "byte position beyond header")
  `IHC_ASSERT_NEXT(a_verdict_closes, res_valid, vg_r, "verdict given but packet still open")
  `IHC_ASSERT_NOW(a_len_zero_early,
    res_valid,
    (res.verdict == VERDICT_VERSION || res.verdict == VERDICT_LENGTH) ==
      (res.header_bytes == 6'd0),
    "header length inconsistent with verdict")
  `IHC_ASSERT_NOW(a_res_on_step, res_valid, step, "result without a step")

endmodule

>>> hdl/ihc_out_stage.sv
// ---------------------------------------------------------------------------
// IPv4 header checker output stage
// Result register; frees the pipeline whenever it is empty or being taken.
// ---------------------------------------------------------------------------
module ihc_out_stage
  import ihc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_valid,
  input  ihc_out_t res,
  output logic     advance,
  output logic     out_valid,
  input  logic     out_ready,
  output ihc_out_t out_data
);

  logic     valid_r;
  ihc_out_t data_r;

  assign advance = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
